FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define RTB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RTB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rtb_pkg.sv
package rtb_pkg;

  // request codes carried in tuser
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // fixed field widths
  localparam int COUNT_W    = 32;
  localparam int OWNER_W    = 16;
  localparam int TAG_W      = 32;
  localparam int SLOT_IDX_W = 4;

  // one slot record as held in the slot ram
  typedef struct packed {
    logic [COUNT_W-1:0] remaining;
    logic [COUNT_W-1:0] reload;
    logic [OWNER_W-1:0] owner;
    logic [TAG_W-1:0]   tag;
    logic               notify;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  // controller to datapath commands
  typedef struct packed {
    logic tick_go;
    logic slot_load;
    logic slot_clear;
    logic walk;
    logic flush;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic walk_done;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/reloadable_timer_bank.sv
// channel   dir  data / side fields
// s_axis    in   tuser: cmd; tdata: ticks, slot, counts, owner, tag, listens
// m_axis    out  tdata: expired owner, tag, slot; tlast: last expiry of a tick
//
// start, stop and unused requests are taken in the idle state and leave it idle
// a tick walks every slot through the slot ram, one slot a cycle unless stalled:
//   tready stays low from the tick request through the walk and the flush,
//   and the walk is paced by the single ram read port
// a full output register stalls the walk while two expiries are waiting
// rst clears all active marks at once; the slot ram needs no clearing
module reloadable_timer_bank
  import rtb_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] elapsed_ticks, [35:32] slot_index, [67:36] start_count,
  // [99:68] reload_count, [115:100] owner_handle, [147:116] timer_tag,
  // [148] owner_listens, [151:149] zero
  input  logic [151:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] expired_owner, [47:16] expired_tag, [51:48] expired_slot, [55:52] zero
  output logic [55:0]  m_axis_tdata,
  // last_of_run
  output logic         m_axis_tlast
);

  `include "assert_macros.svh"

  ctrl_cmd_t             cmd;
  dp_stat_t              stat;
  logic [OWNER_W-1:0]    expired_owner;
  logic [TAG_W-1:0]      expired_tag;
  logic [SLOT_IDX_W-1:0] expired_slot;

  rtb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtb_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .elapsed_ticks (s_axis_tdata[31:0]),
    .slot_index    (s_axis_tdata[35:32]),
    .start_count   (s_axis_tdata[67:36]),
    .reload_count  (s_axis_tdata[99:68]),
    .owner_handle  (s_axis_tdata[115:100]),
    .timer_tag     (s_axis_tdata[147:116]),
    .owner_listens (s_axis_tdata[148]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .expired_owner (expired_owner),
    .expired_tag   (expired_tag),
    .expired_slot  (expired_slot),
    .last_of_run   (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = {4'd0, expired_slot, expired_tag, expired_owner};

  // a tick request blocks new requests on the next cycle
  `RTB_ASSERT(a_tick_blocks, (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_TICK) |=> !s_axis_tready, "tick request did not start a walk")
  // a non-final expiry is only ever shown while a walk is running
  `RTB_ASSERT(a_mid_in_walk, (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready, "non-final expiry outside a walk")
  // at most one controller command a cycle
  `RTB_ASSERT(a_cmd_onehot, $onehot0(cmd), "several controller commands at once")
  // reset leaves no result behind
  `RTB_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

FILE: rtl/rtb_ram.sv
module rtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/rtb_ctrl.sv
module rtb_ctrl
  import rtb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;

  assign in_ready = (state == ST_IDLE);
  assign take     = in_ready && in_valid;

  // command decode and next state
  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (in_cmd)
            CMD_TICK: begin
              cmd.tick_go = 1'b1;
              state_next  = ST_WALK;
            end
            CMD_START: cmd.slot_load  = 1'b1;
            CMD_STOP:  cmd.slot_clear = 1'b1;
            default:   cmd = '0;
          endcase
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (!stat.pend_valid || stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/rtb_datapath.sv
module rtb_datapath
  import rtb_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic [COUNT_W-1:0]    elapsed_ticks,
  input  logic [SLOT_IDX_W-1:0] slot_index,
  input  logic [COUNT_W-1:0]    start_count,
  input  logic [COUNT_W-1:0]    reload_count,
  input  logic [OWNER_W-1:0]    owner_handle,
  input  logic [TAG_W-1:0]      timer_tag,
  input  logic                  owner_listens,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OWNER_W-1:0]    expired_owner,
  output logic [TAG_W-1:0]      expired_tag,
  output logic [SLOT_IDX_W-1:0] expired_slot,
  output logic                  last_of_run
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int PTR_W  = SLOT_W + 1;
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(TIMER_SLOTS);

  logic [TIMER_SLOTS-1:0] active;
  logic [COUNT_W-1:0]     ticks_q;
  logic [PTR_W-1:0]       rd_ptr;
  logic                   stg_valid;
  logic [SLOT_W-1:0]      stg_slot;

  logic                   pend_valid;
  logic [OWNER_W-1:0]     pend_owner;
  logic [TAG_W-1:0]       pend_tag;
  logic [SLOT_IDX_W-1:0]  pend_slot;

  slot_rec_t              rec;
  slot_rec_t              upd_rec;
  slot_rec_t              new_rec;
  logic [REC_W-1:0]       rd_bits;
  logic                   idx_ok;
  logic                   hit;
  logic                   expire;
  logic                   notify_hit;
  logic                   out_free;
  logic                   stall;
  logic                   adv;
  logic                   rd_en;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  logic [REC_W-1:0]       wr_data;
  logic                   load_mid;
  logic                   load_end;

  // slot check for start and stop
  assign idx_ok = (32'(slot_index) < TIMER_SLOTS);

  // current slot evaluation
  assign rec        = slot_rec_t'(rd_bits);
  assign hit        = stg_valid && active[stg_slot];
  assign expire     = hit && !(rec.remaining > ticks_q);
  assign notify_hit = expire && rec.notify;

  // output hand-off and walk stall
  assign out_free = !out_valid || out_ready;
  assign stall    = notify_hit && pend_valid && !out_free;
  assign adv      = cmd.walk && !stall;
  assign rd_en    = adv && (rd_ptr != PTR_END);
  assign load_mid = adv && notify_hit && pend_valid;
  assign load_end = cmd.flush && pend_valid && out_free;

  // record written back after a walk step
  always_comb begin
    upd_rec = rec;
    if (expire) begin
      upd_rec.remaining = rec.reload;
    end else begin
      upd_rec.remaining = rec.remaining - ticks_q;
    end
  end

  // record loaded by a start request
  always_comb begin
    new_rec.remaining = start_count;
    new_rec.reload    = reload_count;
    new_rec.owner     = owner_handle;
    new_rec.tag       = timer_tag;
    new_rec.notify    = owner_listens;
  end

  // ram write port: start loads, walk writes back
  always_comb begin
    if (cmd.slot_load && idx_ok) begin
      wr_en   = 1'b1;
      wr_addr = SLOT_W'(slot_index);
      wr_data = REC_W'(new_rec);
    end else begin
      wr_en   = adv && hit;
      wr_addr = stg_slot;
      wr_data = REC_W'(upd_rec);
    end
  end

  rtb_ram #(
    .WIDTH (REC_W),
    .DEPTH (TIMER_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[SLOT_W-1:0]),
    .rd_data (rd_bits)
  );

  // active marks
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      if (cmd.slot_load && idx_ok) begin
        active[SLOT_W'(slot_index)] <= 1'b1;
      end else if (cmd.slot_clear && idx_ok) begin
        active[SLOT_W'(slot_index)] <= 1'b0;
      end else if (adv && expire && (rec.reload == '0)) begin
        active[stg_slot] <= 1'b0;
      end
    end
  end

  // elapsed count for the walk
  always_ff @(posedge clk) begin
    if (cmd.tick_go) begin
      ticks_q <= elapsed_ticks;
    end
  end

  // read pointer and read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      stg_valid <= 1'b0;
      stg_slot  <= '0;
    end else if (cmd.tick_go) begin
      rd_ptr    <= '0;
      stg_valid <= 1'b0;
    end else if (adv) begin
      stg_valid <= rd_en;
      if (rd_en) begin
        rd_ptr   <= rd_ptr + 1'b1;
        stg_slot <= rd_ptr[SLOT_W-1:0];
      end
    end
  end

  // pending result, held until the next one shows whether it is last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (adv && notify_hit) begin
      pend_valid <= 1'b1;
    end else if (load_end) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && notify_hit) begin
      pend_owner <= rec.owner;
      pend_tag   <= rec.tag;
      pend_slot  <= SLOT_IDX_W'(stg_slot);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_mid || load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid || load_end) begin
      expired_owner <= pend_owner;
      expired_tag   <= pend_tag;
      expired_slot  <= pend_slot;
      last_of_run   <= load_end;
    end
  end

  // status back to the controller
  assign stat.walk_done  = (rd_ptr == PTR_END) && !stg_valid;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

endmodule

FILE: bench/timer_bank_expiry_checker.sv
`timescale 1ns / 100ps

// watches both streams, keeps its own copy of the timer slots and checks
// every expiry that leaves the bank against the oldest one predicted
module timer_bank_expiry_checker
  import rtb_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [55:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           mismatches,
  output int           pending_expiries
);

  // a tick can never report more expiries than this
  localparam int MAX_EXPIRIES = 16;

  typedef struct packed {
    logic [OWNER_W-1:0]    owner;
    logic [TAG_W-1:0]      tag;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  last;
  } expiry_t;

  // predicted slot contents
  bit                  slot_on      [TIMER_SLOTS];
  logic [COUNT_W-1:0]  count_left   [TIMER_SLOTS];
  logic [COUNT_W-1:0]  reload_store [TIMER_SLOTS];
  logic [OWNER_W-1:0]  owner_store  [TIMER_SLOTS];
  logic [TAG_W-1:0]    tag_store    [TIMER_SLOTS];
  bit                  notify_store [TIMER_SLOTS];

  expiry_t expected_expiries[$];
  int      error_total = 0;

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: expiry %s mismatch, expected %h, actual %h", $time, what, want, got);
      error_total++;
    end
  endfunction

  // compare one expiry leaving the bank with the oldest prediction
  task automatic check_expiry();
    expiry_t want;
    if (expected_expiries.size() == 0) begin
      $display("%0t: unexpected expiry, expected none, actual owner %h tag %h slot %h last %b",
               $time, m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tdata[51:48],
               m_axis_tlast);
      error_total++;
    end else begin
      want = expected_expiries.pop_front();
      check_field("owner", 32'(want.owner), 32'(m_axis_tdata[15:0]));
      check_field("tag", want.tag, m_axis_tdata[47:16]);
      check_field("slot", 32'(want.slot), 32'(m_axis_tdata[51:48]));
      check_field("last", 32'(want.last), 32'(m_axis_tlast));
      check_field("padding", 32'd0, 32'(m_axis_tdata[55:52]));
    end
  endtask

  // apply one accepted request to the slot copy and queue its expiries
  task automatic apply_request(input logic [1:0] cmd, input logic [151:0] data);
    logic [COUNT_W-1:0]    elapsed;
    logic [SLOT_IDX_W-1:0] idx;
    expiry_t               held;
    int                    fired;
    elapsed = data[31:0];
    idx     = data[35:32];
    fired   = 0;
    held    = '0;
    case (cmd)
      CMD_TICK: begin
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (slot_on[s]) begin
            if (count_left[s] > elapsed) begin
              count_left[s] = count_left[s] - elapsed;
            end else begin
              // expired: reload, or drop a one-shot
              if (reload_store[s] != '0) begin
                count_left[s] = reload_store[s];
              end else begin
                slot_on[s] = 1'b0;
              end
              if (notify_store[s] && fired < MAX_EXPIRIES) begin
                // the previous one is now known not to be the last
                if (fired > 0) begin
                  expected_expiries.push_back(held);
                end
                held.owner = owner_store[s];
                held.tag   = tag_store[s];
                held.slot  = SLOT_IDX_W'(s);
                held.last  = 1'b0;
                fired++;
              end
            end
          end
        end
        if (fired > 0) begin
          held.last = 1'b1;
          expected_expiries.push_back(held);
        end
      end
      CMD_START: begin
        if (int'(idx) < TIMER_SLOTS) begin
          count_left[idx]   = data[67:36];
          reload_store[idx] = data[99:68];
          owner_store[idx]  = data[115:100];
          tag_store[idx]    = data[147:116];
          notify_store[idx] = data[148];
          slot_on[idx]      = 1'b1;
        end
      end
      CMD_STOP: begin
        if (int'(idx) < TIMER_SLOTS) begin
          slot_on[idx] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // results first, then the new request
  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_on[s]) slot_on[s] = 1'b0;
      expected_expiries.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_expiry();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(s_axis_tuser, s_axis_tdata);
      end
    end
    pending_expiries <= expected_expiries.size();
    mismatches       <= error_total;
  end

endmodule

FILE: bench/reloadable_timer_bank_tb.sv
`timescale 1ns / 100ps

module reloadable_timer_bank_tb;
  import rtb_pkg::*;

  localparam int         TIMER_SLOTS = 16;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         WORK_ITEMS  = 420;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // [31:0] elapsed_ticks, [35:32] slot_index, [67:36] start_count,
  // [99:68] reload_count, [115:100] owner_handle, [147:116] timer_tag,
  // [148] owner_listens, [151:149] zero
  logic [151:0] s_axis_tdata;
  // [1:0] cmd
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [15:0] expired_owner, [47:16] expired_tag, [51:48] expired_slot, [55:52] zero
  logic [55:0]  m_axis_tdata;
  // last_of_run
  logic         m_axis_tlast;

  int mismatches;
  int pending_expiries;
  int work_items = 0;
  bit steady     = 1'b0;
  bit sink_hold  = 1'b0;
  bit squeezed   = 1'b0;
  int cycle_count = 0;

  reloadable_timer_bank #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  timer_bank_expiry_checker #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) expiry_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .mismatches(mismatches),
    .pending_expiries(pending_expiries)
  );

  // 250 MHz clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // every field random, padding zero
  function automatic logic [151:0] random_fields();
    return {3'b000, 1'($urandom_range(0, 1)), 32'($urandom()), 16'($urandom()),
            32'($urandom()), 32'($urandom()), 4'($urandom()), 32'($urandom())};
  endfunction

  // offer one request and hold it until the bank takes it
  task automatic send_request(input logic [1:0] cmd, input logic [151:0] data);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 33);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    if (cmd != CMD_UNUSED) begin
      work_items++;
    end
  endtask

  task automatic start_slot(input logic [3:0] slot, input logic [31:0] first,
                            input logic [31:0] reload, input logic [15:0] owner,
                            input logic [31:0] tag, input logic listens);
    logic [151:0] data;
    data            = random_fields();
    data[35:32]     = slot;
    data[67:36]     = first;
    data[99:68]     = reload;
    data[115:100]   = owner;
    data[147:116]   = tag;
    data[148]       = listens;
    send_request(CMD_START, data);
  endtask

  task automatic stop_slot(input logic [3:0] slot);
    logic [151:0] data;
    data        = random_fields();
    data[35:32] = slot;
    send_request(CMD_STOP, data);
  endtask

  task automatic run_tick(input logic [31:0] elapsed);
    logic [151:0] data;
    data       = random_fields();
    data[31:0] = elapsed;
    send_request(CMD_TICK, data);
  endtask

  // mostly short counts so that ticks keep hitting expiries
  function automatic logic [31:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(0, 12);
    if (roll < 85) return $urandom_range(0, 200);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_reload();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 32'd0;
    if (roll < 80) return $urandom_range(1, 12);
    return $urandom();
  endfunction

  // load every slot with a near count, then tick them all out;
  // with squeeze the receiver holds off so the bank backs up
  task automatic fill_every_slot(input bit squeeze);
    for (int s = 0; s < TIMER_SLOTS; s++) begin
      start_slot(4'(s), $urandom_range(0, 3), pick_reload(), 16'($urandom()),
                 $urandom(), $urandom_range(0, 9) != 0);
    end
    if (squeeze) begin
      sink_hold = 1'b1;
    end
    repeat (4) run_tick($urandom_range(1, 3));
  endtask

  // receiver side
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold = 1'b0;
      end
      m_axis_tready <= rst || steady || ($urandom_range(0, 99) >= 33);
    end
  end

  // sender side and verdict
  initial begin
    int roll;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    rst           = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners
    run_tick(32'd0);
    start_slot(4'd0, 32'd0, 32'd0, 16'hffff, 32'hffffffff, 1'b1);
    run_tick(32'd0);
    start_slot(4'd15, 32'hffffffff, 32'hffffffff, 16'h0000, 32'h00000000, 1'b1);
    run_tick(32'hffffffff);
    start_slot(4'd3, 32'd10, 32'd0, 16'h1234, 32'h5a5a5a5a, 1'b0);
    run_tick(32'd10);
    start_slot(4'd5, 32'd7, 32'd3, 16'h00ff, 32'h80000001, 1'b1);
    // restart of a running slot
    start_slot(4'd5, 32'd2, 32'd3, 16'hff00, 32'h7ffffffe, 1'b1);
    stop_slot(4'd7);
    send_request(CMD_UNUSED, random_fields());
    run_tick(32'd2);
    run_tick(32'd1);
    stop_slot(4'd15);
    run_tick(32'd3);
    stop_slot(4'd5);
    run_tick(32'hffffffff);

    // random traffic
    while (work_items < WORK_ITEMS) begin
      steady = (work_items >= 200 && work_items < 260);
      if (!squeezed && work_items >= 100) begin
        squeezed = 1'b1;
        fill_every_slot(1'b1);
      end else if ($urandom_range(0, 99) < 3) begin
        fill_every_slot(1'b0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 38) begin
        start_slot(4'($urandom()), pick_count(), pick_reload(), 16'($urandom()),
                   $urandom(), $urandom_range(0, 4) != 0);
      end else if (roll < 50) begin
        stop_slot(4'($urandom()));
      end else if (roll < 54) begin
        send_request(CMD_UNUSED, random_fields());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) run_tick(32'd0);
        else if (roll < 75) run_tick($urandom_range(1, 6));
        else if (roll < 90) run_tick($urandom_range(7, 100));
        else run_tick($urandom());
      end
    end
    steady = 1'b0;

    // drain
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_expiries == 0);
    repeat (2 * TIMER_SLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/rtb_pkg.sv
rtl/rtb_ram.sv
rtl/rtb_ctrl.sv
rtl/rtb_datapath.sv
rtl/reloadable_timer_bank.sv
bench/timer_bank_expiry_checker.sv
bench/reloadable_timer_bank_tb.sv
